// File: rtl/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam logic [15:0] RELOAD_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_OOM  = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [7:0]  owner;
    logic [31:0] tag;
    logic [31:0] deadline;
  } slot_t;

endpackage
`default_nettype wire

// File: rtl/tss_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  owner_id;
  logic [31:0] tag;
  logic [31:0] amount;

  modport source (output valid, output operation, output owner_id, output tag,
                  output amount, input ready);
  modport sink (input valid, input operation, input owner_id, input tag,
                input amount, output ready);
endinterface
`default_nettype wire

// File: rtl/tss_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tss_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        status;
  logic [7:0]  expired_owner;
  logic [31:0] expired_tag;
  logic        running;
  logic [15:0] next_delay;
  logic        last;

  modport source (output valid, output kind, output status, output expired_owner,
                  output expired_tag, output running, output next_delay,
                  output last, input ready);
  modport sink (input valid, input kind, input status, input expired_owner,
                input expired_tag, input running, input next_delay, input last,
                output ready);
endinterface
`default_nettype wire

// File: rtl/tss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tss_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 shift_en,
  input  tss_pkg::slot_t      slot_in,
  input  wire                 sel_in,
  input  wire                 sel_load,
  input  wire                 sel_value,
  input  wire  [7:0]          key_owner,
  input  wire  [31:0]         key_tag,
  output tss_pkg::slot_t      slot_q,
  output logic                sel_q,
  output logic                match
);

  logic        valid_r;
  logic [7:0]  owner_r;
  logic [31:0] tag_r;
  logic [31:0] deadline_r;
  logic        sel_r;

  // Valid bit is control state; payload follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (shift_en) begin
      valid_r <= slot_in.valid;
      sel_r   <= sel_in;
    end else if (sel_load) begin
      sel_r <= sel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      owner_r    <= slot_in.owner;
      tag_r      <= slot_in.tag;
      deadline_r <= slot_in.deadline;
    end
  end

  assign slot_q = {valid_r, owner_r, tag_r, deadline_r};
  assign sel_q  = sel_r;
  assign match  = valid_r && (owner_r == key_owner) && (tag_r == key_tag);

endmodule
`default_nettype wire

// File: rtl/timeout_slot_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// An item runs from input transfer via match and scan to its status transfer;
// sink stalls lengthen this. Expiry results overlap the scan. Items are taken only
// in idle; the ring rotates once per item past the single head unit, which checks,
// updates and ranks one slot a cycle unless an expiry waits on a busy output.
// Reset (synchronous, rst_n low): all slots free, time zero, reload_period 65535.
module timeout_slot_scheduler #(
  parameter int unsigned SLOTS = tss_pkg::SLOTS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst_n,
  tss_in_if.sink      in_ch,
  tss_out_if.source   out_ch,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MATCH  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_STATUS = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Captured item
  tss_pkg::op_t op_r;
  logic [7:0]   owner_r;
  logic [31:0]  tag_r;
  logic [31:0]  amount_r;
  logic [31:0]  now_r;
  logic [31:0]  new_dl_r;
  logic         oom_r;
  logic [15:0]  reload_r;
  logic [IW-1:0] step_r;

  // Earliest-deadline tracking as a signed distance from now
  logic         found_r;
  logic [31:0]  best_r;

  // Output register
  logic         out_valid_r;
  logic         out_kind_r, out_status_r, out_running_r, out_last_r;
  logic [7:0]   out_owner_r;
  logic [31:0]  out_tag_r;
  logic [15:0]  out_delay_r;

  // Ring of cells
  tss_pkg::slot_t slot_q [SLOTS];
  tss_pkg::slot_t slot_d [SLOTS];
  logic [SLOTS-1:0] sel_vec, match_vec, free_vec, pick_vec;
  logic             shift_en, sel_load;
  tss_pkg::slot_t   head_mod;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      logic sel_next;
      if (g == SLOTS - 1) begin : g_tail
        assign slot_d[g] = head_mod;
        assign sel_next  = 1'b0;
      end else begin : g_mid
        assign slot_d[g] = slot_q[g+1];
        assign sel_next  = sel_vec[g+1];
      end
      tss_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (shift_en),
        .slot_in   (slot_d[g]),
        .sel_in    (sel_next),
        .sel_load  (sel_load),
        .sel_value (pick_vec[g]),
        .key_owner (owner_r),
        .key_tag   (tag_r),
        .slot_q    (slot_q[g]),
        .sel_q     (sel_vec[g]),
        .match     (match_vec[g])
      );
      assign free_vec[g] = !slot_q[g].valid;
    end
  endgenerate

  // Pick the target slot: lowest match, else lowest free slot for set
  logic [SLOTS-1:0] match_low, free_low;
  logic             no_room;
  assign match_low = match_vec & (~match_vec + {{(SLOTS-1){1'b0}}, 1'b1});
  assign free_low  = free_vec & (~free_vec + {{(SLOTS-1){1'b0}}, 1'b1});
  assign no_room   = (match_vec == '0) && (free_vec == '0);

  always_comb begin
    unique case (op_r)
      tss_pkg::OP_SET:   pick_vec = (match_vec != '0) ? match_low : free_low;
      tss_pkg::OP_CLEAR: pick_vec = match_low;
      tss_pkg::OP_TICK:  pick_vec = '0;
      tss_pkg::OP_NONE:  pick_vec = '0;
      default:           pick_vec = '0;
    endcase
  end

  // Head unit: update, expire and rank the slot leaving cell 0
  logic [31:0] delta;
  logic        due, out_free, step_ok, better, out_load;

  always_comb begin
    head_mod = slot_q[0];
    if (sel_vec[0] && op_r == tss_pkg::OP_SET) begin
      head_mod.valid    = 1'b1;
      head_mod.owner    = owner_r;
      head_mod.tag      = tag_r;
      head_mod.deadline = new_dl_r;
    end else if (sel_vec[0] && op_r == tss_pkg::OP_CLEAR) begin
      head_mod.valid = 1'b0;
    end
    delta = head_mod.deadline - now_r;
    due   = head_mod.valid && (op_r == tss_pkg::OP_TICK) && ((delta == '0) || delta[31]);
    // Drop a fired slot on its way back into the ring
    if (due) begin
      head_mod.valid = 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign step_ok  = !due || out_free;
  assign shift_en = (state_r == ST_SCAN) && step_ok;
  assign sel_load = (state_r == ST_MATCH);
  assign better   = head_mod.valid && (!found_r || ($signed(delta) < $signed(best_r)));
  // Load the output register with an expiry during the scan or the closing status
  assign out_load = (shift_en && due) || (state_r == ST_STATUS && out_free);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_MATCH;
      ST_MATCH:  state_nxt = ST_SCAN;
      ST_SCAN:   if (step_ok && step_r == IW'(SLOTS - 1)) state_nxt = ST_STATUS;
      ST_STATUS: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      reload_r    <= tss_pkg::RELOAD_RESET;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      found_r     <= 1'b0;
      oom_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        reload_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          step_r  <= '0;
          found_r <= 1'b0;
        end
        ST_MATCH: begin
          // Advance time before the scan checks deadlines
          if (op_r == tss_pkg::OP_TICK) begin
            now_r <= now_r + amount_r;
          end
          oom_r <= (op_r == tss_pkg::OP_SET) && no_room;
        end
        ST_SCAN: begin
          if (step_ok) begin
            step_r <= step_r + IW'(1);
            if (better) begin
              found_r <= 1'b1;
            end
          end
        end
        ST_STATUS: ;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r     <= tss_pkg::op_t'(in_ch.operation);
      owner_r  <= in_ch.owner_id;
      tag_r    <= in_ch.tag;
      amount_r <= in_ch.amount;
    end
    if (state_r == ST_MATCH) begin
      new_dl_r <= now_r + amount_r;
    end
    if (shift_en && better) begin
      best_r <= delta;
    end
    if (shift_en && due) begin
      out_kind_r    <= tss_pkg::KIND_EXPIRY;
      out_status_r  <= tss_pkg::STATUS_OK;
      out_owner_r   <= slot_q[0].owner;
      out_tag_r     <= slot_q[0].tag;
      out_running_r <= 1'b0;
      out_delay_r   <= '0;
      out_last_r    <= 1'b0;
    end else if (state_r == ST_STATUS && out_free) begin
      out_kind_r    <= tss_pkg::KIND_STATUS;
      out_status_r  <= oom_r ? tss_pkg::STATUS_OOM : tss_pkg::STATUS_OK;
      out_owner_r   <= '0;
      out_tag_r     <= '0;
      out_running_r <= found_r;
      out_delay_r   <= (found_r && (best_r < {16'd0, reload_r})) ? best_r[15:0] : reload_r;
      out_last_r    <= 1'b1;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.expired_owner = out_owner_r;
  assign out_ch.expired_tag   = out_tag_r;
  assign out_ch.running       = out_running_r;
  assign out_ch.next_delay    = out_delay_r;
  assign out_ch.last          = out_last_r;

`ifndef NO_ASSERTIONS
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> $onehot0(sel_vec))
    else $error("more than one target slot selected");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STATUS && out_free) |=> (out_ch.valid && out_ch.last))
    else $error("status transfer not presented with last");

  a_oom_set_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && oom_r) |-> (op_r == tss_pkg::OP_SET && sel_vec == '0))
    else $error("out of memory outside a set or with a target");

  a_no_shift_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !shift_en)
    else $error("ring rotated while idle");
`endif

endmodule
`default_nettype wire
